FILE: rtl/lsfadpcm_pkg.sv
// ----------------------------------------------------------------------------
// lsfadpcm_pkg: shared types and constants of the 4-bit ADPCM decoder
// Widths, the header state carried to the sample unit and the predictor
// coefficient table.
// ----------------------------------------------------------------------------
package lsfadpcm_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NIBBLE_W   = 4;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned COEF_W     = 8;
   localparam int unsigned UNITY_SHIFT = 12;  // shift at which a nibble is not scaled
   localparam int unsigned PRED_FRAC  = 6;    // predictor sum is in 1/64 units

   // Shift and filter taken from the last header transaction.
   typedef struct packed {
      logic [NIBBLE_W-1:0] scale_shift;
      logic [NIBBLE_W-1:0] filter_select;
   } hdr_state_type;

   // Newer-history coefficient; filter one and filters five and above are zero.
   function automatic logic signed [COEF_W-1:0] coef_newer(input logic [NIBBLE_W-1:0] sel);
      logic signed [COEF_W-1:0] c;
      unique case (sel)
         4'd0:    c = 8'sd115;
         4'd2:    c = 8'sd98;
         4'd3:    c = 8'sd60;
         4'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   // Coefficient on the older history sample.
   function automatic logic signed [COEF_W-1:0] coef_older(input logic [NIBBLE_W-1:0] sel);
      logic signed [COEF_W-1:0] c;
      unique case (sel)
         4'd0:    c = -8'sd52;
         4'd2:    c = -8'sd55;
         4'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/lsfadpcm_sample.sv
// ----------------------------------------------------------------------------
// lsfadpcm_sample: one-sample decode datapath
// Scale the signed nibble, add the two-tap prediction (truncated toward
// zero) and saturate to 16 bits.
// ----------------------------------------------------------------------------
module lsfadpcm_sample (
   input  lsfadpcm_pkg::hdr_state_type                  hdr_state,
   input  logic [lsfadpcm_pkg::NIBBLE_W-1:0]            nibble,
   input  logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]     newer_hist,
   input  logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]     older_hist,
   output logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]     sample
);

   localparam int unsigned SCALED_W = lsfadpcm_pkg::SAMPLE_W + 1;
   localparam int unsigned PROD_W   = lsfadpcm_pkg::SAMPLE_W + lsfadpcm_pkg::COEF_W;
   localparam int unsigned ACC_W    = PROD_W + 1;
   localparam int unsigned PRED_W   = ACC_W - lsfadpcm_pkg::PRED_FRAC;
   localparam int unsigned SUM_W    = PRED_W + 1;

   logic signed [SCALED_W-1:0] nib_ext;
   logic signed [SCALED_W-1:0] scaled;
   logic [lsfadpcm_pkg::NIBBLE_W-1:0] shift_amt;
   logic signed [PROD_W-1:0] prod_newer;
   logic signed [PROD_W-1:0] prod_older;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_adj;
   logic signed [PRED_W-1:0] pred;
   logic signed [SUM_W-1:0]  total;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (lsfadpcm_pkg::SAMPLE_W-1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (lsfadpcm_pkg::SAMPLE_W-1));
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << lsfadpcm_pkg::PRED_FRAC) - 1);
   localparam logic [lsfadpcm_pkg::NIBBLE_W-1:0] UNITY =
      lsfadpcm_pkg::NIBBLE_W'(lsfadpcm_pkg::UNITY_SHIFT);

   always_comb begin
      nib_ext = SCALED_W'($signed(nibble));
      // Shifts above unity become an arithmetic right shift (floor).
      if (hdr_state.scale_shift <= UNITY) begin
         shift_amt = UNITY - hdr_state.scale_shift;
         scaled    = nib_ext <<< shift_amt;
      end else begin
         shift_amt = hdr_state.scale_shift - UNITY;
         scaled    = nib_ext >>> shift_amt;
      end
   end

   assign prod_newer = newer_hist * lsfadpcm_pkg::coef_newer(hdr_state.filter_select);
   assign prod_older = older_hist * lsfadpcm_pkg::coef_older(hdr_state.filter_select);
   assign acc        = ACC_W'(prod_newer) + ACC_W'(prod_older);
   // Divide by 64 toward zero: bias negative sums before the shift.
   assign acc_adj    = acc[ACC_W-1] ? (acc + TRUNC_BIAS) : acc;
   assign pred       = PRED_W'(acc_adj >>> lsfadpcm_pkg::PRED_FRAC);
   assign total      = SUM_W'(scaled) + SUM_W'(pred);

   always_comb begin
      if (total > SAT_MAX) begin
         sample = lsfadpcm_pkg::SAMPLE_W'(SAT_MAX);
      end else if (total < SAT_MIN) begin
         sample = lsfadpcm_pkg::SAMPLE_W'(SAT_MIN);
      end else begin
         sample = lsfadpcm_pkg::SAMPLE_W'(total);
      end
   end

endmodule

FILE: rtl/lsf_adpcm_decoder_core.sv
// ----------------------------------------------------------------------------
// lsf_adpcm_decoder_core: PSX-style 4-bit ADPCM decoder, mono
// Byte-stream in, 16-bit PCM sample stream out.
// ----------------------------------------------------------------------------
// Feed one encoded byte per request transaction, with req_tuser high on the
// frame's header byte. A header transaction gives no sample; it loads the
// inverted shift (high nibble) and filter (low nibble). Every other byte
// gives two response transactions, low nibble first, the second flagged by
// rsp_tlast. A data byte occupies the decoder until both of its samples are
// decoded, one after the other, because each sample feeds the history used
// by the next. A new byte is taken in the cycle the previous one finishes. A
// finished sample waits in the response register; while it waits no further
// nibble is decoded, so a data byte holds the input register until the
// receiver takes the sample, whereas a header still passes. History and
// header state start at zero and carry across frames; frame length is not
// checked.
// ----------------------------------------------------------------------------
module lsf_adpcm_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] is_header
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] pcm_sample
   output logic        rsp_tlast    // high on the high-nibble sample
);

   // Input register: holds the byte until both nibbles are decoded.
   logic                                      in_valid_ff, in_valid_in;
   logic [lsfadpcm_pkg::BYTE_W-1:0]           in_byte_ff, in_byte_in;
   logic                                      in_hdr_ff, in_hdr_in;
   logic                                      phase_ff, phase_in;   // 1: high nibble next

   // Decoder state.
   lsfadpcm_pkg::hdr_state_type               hdr_ff, hdr_in;
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]  newer_ff, newer_in;
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]  older_ff, older_in;

   // Response register.
   logic                                      out_valid_ff, out_valid_in;
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                                      out_last_ff, out_last_in;

   logic                                      out_free;
   logic                                      step;
   logic                                      data_step;
   logic                                      in_done;
   logic [lsfadpcm_pkg::NIBBLE_W-1:0]         nibble;
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0]  sample;

   // A header needs no response slot; a data nibble needs a free one.
   assign out_free  = !out_valid_ff || rsp_tready;
   assign step      = in_valid_ff && (in_hdr_ff || out_free);
   assign data_step = step && !in_hdr_ff;
   assign in_done   = step && (in_hdr_ff || phase_ff);

   assign req_tready = !in_valid_ff || in_done;

   assign nibble = phase_ff ? in_byte_ff[lsfadpcm_pkg::BYTE_W-1 -: lsfadpcm_pkg::NIBBLE_W]
                            : in_byte_ff[lsfadpcm_pkg::NIBBLE_W-1:0];

   lsfadpcm_sample u_sample (
      .hdr_state  (hdr_ff),
      .nibble     (nibble),
      .newer_hist (newer_ff),
      .older_hist (older_ff),
      .sample     (sample)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_hdr_in     = in_hdr_ff;
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      newer_in      = newer_ff;
      older_in      = older_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;

      // Header: store the inverted nibbles.
      if (step && in_hdr_ff) begin
         hdr_in.scale_shift   = ~in_byte_ff[lsfadpcm_pkg::BYTE_W-1 -: lsfadpcm_pkg::NIBBLE_W];
         hdr_in.filter_select = ~in_byte_ff[lsfadpcm_pkg::NIBBLE_W-1:0];
      end

      // Data: emit one sample, advance the history and the nibble phase.
      if (data_step) begin
         out_valid_in  = 1'b1;
         out_sample_in = sample;
         out_last_in   = phase_ff;
         older_in      = newer_ff;
         newer_in      = sample;
         phase_in      = !phase_ff;
      end

      if (in_done) begin
         in_valid_in = 1'b0;
      end
      // Load the next transaction.
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_hdr_in   = req_tuser;
         phase_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         hdr_ff       <= '0;
         newer_ff     <= '0;
         older_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         hdr_ff       <= hdr_in;
         newer_ff     <= newer_in;
         older_ff     <= older_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_hdr_ff     <= in_hdr_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;

   // The high-nibble phase only exists while a data byte is held.
   a_phase_on_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (in_valid_ff && !in_hdr_ff))
      else $error("nibble phase set without a data byte held");

   // A header never produces a response.
   a_hdr_silent: assert property (@(posedge clock) disable iff (reset)
      (step && in_hdr_ff && rsp_tready) |=> !out_valid_ff)
      else $error("header produced a response");

   // Each decoded sample pushes the previous one into the older history.
   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      data_step |=> (older_ff == $past(newer_ff) && newer_ff == out_sample_ff))
      else $error("history not advanced with the emitted sample");

   // The response flag follows the nibble that was decoded.
   a_last_phase: assert property (@(posedge clock) disable iff (reset)
      data_step |=> (out_valid_ff && out_last_ff == $past(phase_ff)))
      else $error("rsp_tlast does not match the nibble phase");

   // Finishing the high nibble frees the input register in the same cycle.
   a_release: assert property (@(posedge clock) disable iff (reset)
      (data_step && phase_ff) |-> req_tready)
      else $error("input register not released after the high nibble");

endmodule

FILE: tb/lsf_adpcm_decoder_core_test.sv
// ----------------------------------------------------------------------------
// lsf_adpcm_decoder_core_test: self-checking bench for the 4-bit ADPCM decoder
// Streams header and data bytes into the decoder. A behavioural copy of the
// decoder, kept in this module, predicts each PCM sample. A checker process
// compares every response transaction with the oldest predicted sample.
// Both sides idle at random, and one long receiver stall fills the decoder.
// ----------------------------------------------------------------------------
module lsf_adpcm_decoder_core_test;

   // Meaning of req_tuser
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   localparam int RESET_CYCLES   = 8;
   localparam int FRAME_DATA     = 27;    // data bytes after the header in a full frame
   localparam int LONG_HOLD      = 160;   // receiver stall used to fill the decoder
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRED_DIVISOR   = 64;
   localparam int PCM_MAX        = 32767;
   localparam int PCM_MIN        = -32768;

   // One predicted response transaction
   typedef struct packed {
      logic signed [lsfadpcm_pkg::SAMPLE_W-1:0] pcm;
      logic                                     last;
   } pcm_beat_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [lsfadpcm_pkg::BYTE_W-1:0]   req_tdata  = '0;   // [7:0] data_byte
   logic                              req_tuser  = 1'b0; // [0] is_header
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [lsfadpcm_pkg::SAMPLE_W-1:0] rsp_tdata;         // [15:0] pcm_sample
   logic                              rsp_tlast;

   // Behavioural decoder state
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0] model_newer = '0;
   logic signed [lsfadpcm_pkg::SAMPLE_W-1:0] model_older = '0;
   lsfadpcm_pkg::hdr_state_type              model_hdr   = '0;
   pcm_beat_type                             pcm_expected [$];
   pcm_beat_type                             pcm_want;

   bit idle_enabled = 1'b1;
   bit rsp_hold_req = 1'b0;
   int n_errors          = 0;
   int n_bytes_sent      = 0;
   int n_headers_sent    = 0;
   int n_samples_checked = 0;
   int n_saturated       = 0;
   int n_long_holds      = 0;
   int stall_cycles      = 0;

   always #2 clock = ~clock;

   lsf_adpcm_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Predictor weights per filter; filter one and filters above four predict nothing.
   function automatic void filter_weights(input logic [lsfadpcm_pkg::NIBBLE_W-1:0] sel,
                                          output int w_newer, output int w_older);
      w_newer = 0;
      w_older = 0;
      case (sel)
         4'd0: begin
            w_newer = 115;
            w_older = -52;
         end
         4'd2: begin
            w_newer = 98;
            w_older = -55;
         end
         4'd3: begin
            w_newer = 60;
         end
         4'd4: begin
            w_newer = 122;
            w_older = -60;
         end
         default: ;
      endcase
   endfunction

   // Decode one nibble and advance the history.
   function automatic logic signed [lsfadpcm_pkg::SAMPLE_W-1:0] decode_nibble(
      input logic [lsfadpcm_pkg::NIBBLE_W-1:0] nib);
      int w_newer;
      int w_older;
      int signed_nib;
      int step;
      int pred;
      int sum;
      signed_nib = $signed(nib);
      filter_weights(model_hdr.filter_select, w_newer, w_older);
      // Shifts beyond unity turn into an arithmetic right shift (floor).
      if (model_hdr.scale_shift <= lsfadpcm_pkg::UNITY_SHIFT)
         step = signed_nib * (1 << (lsfadpcm_pkg::UNITY_SHIFT - model_hdr.scale_shift));
      else
         step = signed_nib >>> (model_hdr.scale_shift - lsfadpcm_pkg::UNITY_SHIFT);
      // Integer division truncates toward zero.
      pred = (int'(model_newer) * w_newer + int'(model_older) * w_older) / PRED_DIVISOR;
      sum  = step + pred;
      if (sum > PCM_MAX) begin
         sum = PCM_MAX;
         n_saturated++;
      end else if (sum < PCM_MIN) begin
         sum = PCM_MIN;
         n_saturated++;
      end
      model_older = model_newer;
      model_newer = sum[lsfadpcm_pkg::SAMPLE_W-1:0];
      return model_newer;
   endfunction

   // Apply one accepted request transaction to the behavioural decoder.
   task automatic predict_transaction(input logic [lsfadpcm_pkg::BYTE_W-1:0] value,
                                      input logic kind);
      logic [lsfadpcm_pkg::BYTE_W-1:0] inv;
      pcm_beat_type                    beat;
      if (kind == KIND_HEADER) begin
         inv = 8'hFF - value;
         model_hdr.scale_shift   = inv[7:4];
         model_hdr.filter_select = inv[3:0];
         n_headers_sent++;
      end else begin
         beat.pcm  = decode_nibble(value[3:0]);
         beat.last = 1'b0;
         pcm_expected.push_back(beat);
         beat.pcm  = decode_nibble(value[7:4]);
         beat.last = 1'b1;
         pcm_expected.push_back(beat);
      end
      n_bytes_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one byte and hold it until accepted. Enter and leave at a falling
   // edge; valid stays high on exit so back-to-back bytes leave no gap.
   task automatic send_byte(input logic [lsfadpcm_pkg::BYTE_W-1:0] value, input logic kind);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_transaction(value, kind);
      @(negedge clock);
   endtask

   // The header travels inverted on the wire.
   function automatic logic [lsfadpcm_pkg::BYTE_W-1:0] header_byte(
      input logic [lsfadpcm_pkg::NIBBLE_W-1:0] shift,
      input logic [lsfadpcm_pkg::NIBBLE_W-1:0] filter);
      return 8'hFF - {shift, filter};
   endfunction

   // Nibble drawn from the edges of the signed range: 0, 7, -8, -1.
   function automatic logic [lsfadpcm_pkg::NIBBLE_W-1:0] edge_nibble();
      case ($urandom_range(0, 3))
         0:       return 4'h0;
         1:       return 4'h7;
         2:       return 4'h8;
         default: return 4'hF;
      endcase
   endfunction

   // One frame with random content. Most are well formed: a header followed
   // by a full frame of data. The rest are broken: odd lengths, stray headers.
   task automatic random_frame();
      bit          edgy;
      bit          broken;
      int          n_data;
      logic [7:0]  value;
      edgy   = ($urandom_range(0, 3) == 0);
      broken = ($urandom_range(0, 7) == 0);
      // Bias half of the headers towards the live filters and normal shifts.
      if ($urandom_range(0, 1) == 0)
         send_byte(header_byte(4'($urandom_range(0, 12)), 4'($urandom_range(0, 4))),
                   KIND_HEADER);
      else
         send_byte(8'($urandom_range(0, 255)), KIND_HEADER);
      n_data = broken ? int'($urandom_range(0, 40)) : FRAME_DATA;
      for (int i = 0; i < n_data; i++) begin
         value = edgy ? {edge_nibble(), edge_nibble()} : 8'($urandom_range(0, 255));
         if (broken && $urandom_range(0, 9) == 0)
            send_byte(value, KIND_HEADER);
         else
            send_byte(value, KIND_DATA);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Data before any header decodes with shift zero and filter zero.
   task automatic test_reset_defaults();
      send_byte(8'h87, KIND_DATA);
      send_byte(8'h78, KIND_DATA);
   endtask

   // Extremes of the byte for headers and data.
   task automatic test_field_extremes();
      send_byte(8'hFF, KIND_HEADER);   // shift 0, filter 0
      send_byte(8'h00, KIND_DATA);
      send_byte(8'hFF, KIND_DATA);
      send_byte(8'h00, KIND_HEADER);   // shift 15, filter 15
      send_byte(8'h88, KIND_DATA);
      send_byte(8'h77, KIND_DATA);
   endtask

   // Shifts above unity: negative nibbles must round towards minus infinity.
   task automatic test_shift_repair();
      for (int s = 13; s <= 15; s++) begin
         send_byte(header_byte(4'(s), 4'd1), KIND_HEADER);
         send_byte(8'h9F, KIND_DATA);
      end
   endtask

   // Drive the strongest filter into both rails.
   task automatic test_saturation();
      send_byte(header_byte(4'd0, 4'd4), KIND_HEADER);
      send_byte(8'h77, KIND_DATA);
      send_byte(8'h77, KIND_DATA);
      send_byte(8'h88, KIND_DATA);
      send_byte(8'h88, KIND_DATA);
   endtask

   // Remaining filters, and two headers back to back.
   task automatic test_filters();
      send_byte(header_byte(4'd4, 4'd1), KIND_HEADER);
      send_byte(8'h3C, KIND_DATA);
      send_byte(header_byte(4'd6, 4'd2), KIND_HEADER);
      send_byte(8'hA5, KIND_DATA);
      send_byte(header_byte(4'd2, 4'd5), KIND_HEADER);
      send_byte(header_byte(4'd8, 4'd3), KIND_HEADER);
      send_byte(8'h5A, KIND_DATA);
      send_byte(8'hE1, KIND_DATA);
   endtask

   task automatic test_random_frames();
      for (int f = 0; f < 38; f++)
         random_frame();
   endtask

   // Stall the receiver for a long stretch while bytes keep coming, so the
   // decoder fills up and drops req_tready.
   task automatic test_backpressure();
      rsp_hold_req = 1'b1;
      for (int f = 0; f < 3; f++)
         random_frame();
   endtask

   // Finish with no idling on either side.
   task automatic test_tail_no_idle();
      idle_enabled = 1'b0;
      for (int f = 0; f < 7; f++)
         random_frame();
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Receiver: random stalls, plus the long hold when a test asks for it.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            n_long_holds++;
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each response transaction with the oldest predicted sample.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pcm_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d, last %b",
                                      $signed(rsp_tdata), rsp_tlast));
         end else begin
            pcm_want = pcm_expected.pop_front();
            if (rsp_tdata !== pcm_want.pcm)
               report_mismatch($sformatf("sample %0d: pcm got %0d, expected %0d",
                                         n_samples_checked, $signed(rsp_tdata),
                                         pcm_want.pcm));
            if (rsp_tlast !== pcm_want.last)
               report_mismatch($sformatf("sample %0d: tlast got %b, expected %b",
                                         n_samples_checked, rsp_tlast, pcm_want.last));
         end
         n_samples_checked++;
      end
   end

   // Watchdog: count cycles with no transaction on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d cycles without a transaction", stall_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_shift_repair();
      test_saturation();
      test_filters();
      test_random_frames();
      test_backpressure();
      test_tail_no_idle();

      // Release the request side, then drain the outstanding samples.
      req_tvalid <= 1'b0;
      while (pcm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes (%0d headers), checked %0d samples, %0d saturated",
               n_bytes_sent, n_headers_sent, n_samples_checked, n_saturated);
      $display("covered all shifts and filters, broken frames, %0d long receiver stall(s)",
               n_long_holds);
      if (n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
